>>> design/latency_sample_statistics_core_macros.svh
// Assertion macros for the latency sample statistics core
// Used by the top level; no other dependencies
`ifndef LATENCY_SAMPLE_STATISTICS_CORE_MACROS_SVH
`define LATENCY_SAMPLE_STATISTICS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/lss_pkg.sv
// Shared constants and types for the latency sample statistics core
// No dependencies
`default_nettype none
package lss_pkg;
  localparam int MaxSamples = 1024;
  localparam int SampleBits = 24;
  localparam int FracBits   = 8;
  localparam int AddrBits   = $clog2(MaxSamples);
  localparam int CountBits  = AddrBits + 1;
  localparam int SumBits    = 34;
  localparam int SqSumBits  = 58;
  localparam int AluBits    = 80;
  localparam int StepBits   = 7;
  localparam int MulSteps   = SumBits;
  localparam int DivSteps   = AluBits;
  localparam int SqrtSteps  = 32;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;
endpackage
`default_nettype wire

>>> design/lss_store.sv
// Sample store: one write port, one registered read port
// Uses lss_pkg for depth and widths
`default_nettype none
module lss_store (
  input  wire                            clk,
  input  wire                            wr_en,
  input  wire [lss_pkg::AddrBits-1:0]    wr_addr,
  input  wire [lss_pkg::SampleBits-1:0]  wr_data,
  input  wire                            rd_en,
  input  wire [lss_pkg::AddrBits-1:0]    rd_addr,
  output logic [lss_pkg::SampleBits-1:0] rd_data
);
  import lss_pkg::*;

  logic [SampleBits-1:0] mem [MaxSamples];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

>>> design/lss_alu.sv
// Iterative arithmetic unit: shift-add multiply, restoring divide, square root
// One shared add/subtract per step; uses lss_pkg
`default_nettype none
module lss_alu (
  input  wire                           clk,
  input  wire                           rst_n,
  input  lss_pkg::alu_req_t             req,
  input  wire [lss_pkg::AluBits-1:0]    opa,
  input  wire [lss_pkg::AluBits-1:0]    opb,
  output logic                          done,
  output logic [lss_pkg::AluBits-1:0]   result
);
  import lss_pkg::*;

  logic [AluBits-1:0]  a_r, b_r, c_r;
  logic [StepBits-1:0] cnt_r;
  logic                run_r;
  logic                done_r;
  alu_op_t             op_r;

  logic [AluBits-1:0]  x, y;
  logic                sub;
  logic [AluBits:0]    sum;
  logic                ge;

  // operand selection for the shared adder
  always_comb begin
    x   = c_r;
    y   = '0;
    sub = 1'b0;
    unique case (op_r)
      OP_MUL: begin
        x = c_r;
        y = b_r[0] ? a_r : '0;
      end
      OP_DIV: begin
        x   = {c_r[AluBits-2:0], a_r[AluBits-1]};
        y   = b_r;
        sub = 1'b1;
      end
      OP_SQRT: begin
        x   = {c_r[AluBits-3:0], a_r[2*SqrtSteps-1 -: 2]};
        y   = {b_r[AluBits-3:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        x = c_r;
      end
    endcase
  end

  assign sum = sub ? ({1'b0, x} - {1'b0, y}) : ({1'b0, x} + {1'b0, y});
  assign ge  = !sum[AluBits];

  // sequencer and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        op_r  <= req.op;
        run_r <= 1'b1;
        a_r   <= opa;
        c_r   <= '0;
        unique case (req.op)
          OP_MUL:  begin b_r <= opb; cnt_r <= StepBits'(MulSteps); end
          OP_DIV:  begin b_r <= opb; cnt_r <= StepBits'(DivSteps); end
          OP_SQRT: begin b_r <= '0;  cnt_r <= StepBits'(SqrtSteps); end
          default: begin b_r <= opb; cnt_r <= StepBits'(MulSteps); end
        endcase
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == StepBits'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        unique case (op_r)
          OP_MUL: begin
            c_r <= sum[AluBits-1:0];
            a_r <= {a_r[AluBits-2:0], 1'b0};
            b_r <= {1'b0, b_r[AluBits-1:1]};
          end
          OP_DIV: begin
            c_r <= ge ? sum[AluBits-1:0] : x;
            a_r <= {a_r[AluBits-2:0], ge};
          end
          OP_SQRT: begin
            c_r <= ge ? sum[AluBits-1:0] : x;
            b_r <= {b_r[AluBits-2:0], ge};
            a_r <= {a_r[AluBits-3:0], 2'b00};
          end
          default: begin
            c_r <= c_r;
          end
        endcase
      end
    end
  end

  assign done = done_r;

  // result selection per operation
  always_comb begin
    unique case (op_r)
      OP_MUL:  result = c_r;
      OP_DIV:  result = a_r;
      OP_SQRT: result = b_r;
      default: result = c_r;
    endcase
  end
endmodule
`default_nettype wire

>>> design/latency_sample_statistics_core.sv
// Latency sample statistics: loads samples, then reports count, min, max,
// median, mean, variance and deviation. Samples are taken one per cycle
// (start high, busy low) and kept in a 1024-entry store; beyond that they are
// dropped and flagged. The sample marked last closes the set: busy rises and
// the report runs on one iterative unit (two multiplies, two divides and a
// square root), then the median search scans the store 24 times at one entry
// per cycle. The report is shown for exactly one cycle on out_valid; the
// receiver cannot stall, so it must take the beat when it appears. The set is
// then cleared.
// Depends on lss_pkg, lss_store, lss_alu and the macros header.
`default_nettype none
`include "latency_sample_statistics_core_macros.svh"
module latency_sample_statistics_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire [lss_pkg::SampleBits-1:0]   in_latency_us,
  input  wire                             in_last,
  output logic                            out_valid,
  output logic [lss_pkg::CountBits-1:0]   out_sample_count,
  output logic [lss_pkg::SampleBits-1:0]  out_min_us,
  output logic [lss_pkg::SampleBits-1:0]  out_max_us,
  output logic [lss_pkg::SampleBits-1:0]  out_median_us,
  output logic [31:0]                     out_mean_q,
  output logic [55:0]                     out_variance_q,
  output logic [31:0]                     out_stddev_q,
  output logic                            out_empty_set,
  output logic                            out_dropped
);
  import lss_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FLUSH,
    S_GO,
    S_WAIT,
    S_MED_SCAN,
    S_MED_STEP
  } state_t;

  typedef enum logic [2:0] {
    P_NS2,
    P_S1SQ,
    P_VAR,
    P_MEAN,
    P_SQRT
  } phase_t;

  state_t                state_r;
  phase_t                phase_r;
  logic [CountBits-1:0]  count_r;
  logic [SumBits-1:0]    sum_r;
  logic [SqSumBits-1:0]  sumsq_r;
  logic [SampleBits-1:0] min_r, max_r;
  logic                  ovf_r;
  logic [2*SampleBits-1:0] sq_r;
  logic                  sq_vld_r;
  logic [AluBits-1:0]    ns2_r, var_r, mean_r;
  logic [31:0]           sd_r;
  logic [SampleBits-1:0] lo_r, hi_r;
  logic [CountBits-1:0]  idx_r, cnt_r;
  logic                  rvld_r;

  logic                  out_valid_r;
  logic [CountBits-1:0]  out_count_r;
  logic [SampleBits-1:0] out_min_r, out_max_r, out_med_r;
  logic [31:0]           out_mean_r, out_sd_r;
  logic [55:0]           out_var_r;
  logic                  out_empty_r, out_drop_r;

  logic                  accept, store_ok;
  alu_req_t              alu_req;
  logic [AluBits-1:0]    alu_a, alu_b, alu_res;
  logic                  alu_done;
  logic                  rd_en;
  logic [SampleBits-1:0] rd_data;
  logic [SampleBits-1:0] mid, lo_nxt, hi_nxt;
  logic [2*CountBits-1:0] nn;

  assign busy     = (state_r != S_LOAD);
  assign accept   = start && !busy;
  assign store_ok = (count_r != CountBits'(MaxSamples));
  assign nn       = count_r * count_r;

  lss_store u_store (
    .clk     (clk),
    .wr_en   (accept && store_ok),
    .wr_addr (count_r[AddrBits-1:0]),
    .wr_data (in_latency_us),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AddrBits-1:0]),
    .rd_data (rd_data)
  );

  // operands for the iterative unit by report phase
  always_comb begin
    alu_req.start = (state_r == S_GO);
    alu_req.op    = OP_MUL;
    alu_a         = '0;
    alu_b         = '0;
    unique case (phase_r)
      P_NS2: begin
        alu_a = AluBits'(sumsq_r);
        alu_b = AluBits'(count_r);
      end
      P_S1SQ: begin
        alu_a = AluBits'(sum_r);
        alu_b = AluBits'(sum_r);
      end
      P_VAR: begin
        alu_req.op = OP_DIV;
        alu_a      = {ns2_r[AluBits-FracBits-1:0], {FracBits{1'b0}}};
        alu_b      = AluBits'(nn);
      end
      P_MEAN: begin
        alu_req.op = OP_DIV;
        alu_a      = AluBits'({sum_r, {FracBits{1'b0}}});
        alu_b      = AluBits'(count_r);
      end
      P_SQRT: begin
        alu_req.op = OP_SQRT;
        alu_a      = AluBits'({var_r[55:0], {FracBits{1'b0}}});
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  lss_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  // median search: bisection over the value range
  assign rd_en  = (state_r == S_MED_SCAN) && (idx_r < count_r);
  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign hi_nxt = (cnt_r > (count_r >> 1)) ? mid : hi_r;
  assign lo_nxt = (cnt_r > (count_r >> 1)) ? lo_r : mid + 1'b1;

  // sequencer, accumulators and report registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      phase_r     <= P_NS2;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      ovf_r       <= 1'b0;
      sq_vld_r    <= 1'b0;
      rvld_r      <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      sq_vld_r    <= 1'b0;
      if (sq_vld_r) begin
        sumsq_r <= sumsq_r + SqSumBits'(sq_r);
      end
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (store_ok) begin
              count_r  <= count_r + 1'b1;
              sum_r    <= sum_r + SumBits'(in_latency_us);
              sq_r     <= in_latency_us * in_latency_us;
              sq_vld_r <= 1'b1;
              if (in_latency_us < min_r) min_r <= in_latency_us;
              if (in_latency_us > max_r) max_r <= in_latency_us;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last) state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (count_r == '0) begin
            out_valid_r <= 1'b1;
            out_count_r <= '0;
            out_min_r   <= '0;
            out_max_r   <= '0;
            out_med_r   <= '0;
            out_mean_r  <= '0;
            out_var_r   <= '0;
            out_sd_r    <= '0;
            out_empty_r <= 1'b1;
            out_drop_r  <= ovf_r;
            sum_r       <= '0;
            sumsq_r     <= '0;
            min_r       <= '1;
            max_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end else begin
            phase_r <= P_NS2;
            state_r <= S_GO;
          end
        end
        S_GO: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_done) begin
            state_r <= S_GO;
            unique case (phase_r)
              P_NS2:  begin ns2_r <= alu_res; phase_r <= P_S1SQ; end
              P_S1SQ: begin ns2_r <= ns2_r - alu_res; phase_r <= P_VAR; end
              P_VAR:  begin var_r <= alu_res; phase_r <= P_MEAN; end
              P_MEAN: begin mean_r <= alu_res; phase_r <= P_SQRT; end
              P_SQRT: begin
                sd_r    <= alu_res[31:0];
                lo_r    <= '0;
                hi_r    <= '1;
                idx_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_MED_SCAN;
              end
              default: state_r <= S_LOAD;
            endcase
          end
        end
        S_MED_SCAN: begin
          if (rd_en) idx_r <= idx_r + 1'b1;
          rvld_r <= rd_en;
          if (rvld_r && (rd_data <= mid)) cnt_r <= cnt_r + 1'b1;
          if (!rd_en && !rvld_r) state_r <= S_MED_STEP;
        end
        S_MED_STEP: begin
          lo_r <= lo_nxt;
          hi_r <= hi_nxt;
          if (lo_nxt == hi_nxt) begin
            out_valid_r <= 1'b1;
            out_count_r <= count_r;
            out_min_r   <= min_r;
            out_max_r   <= max_r;
            out_med_r   <= lo_nxt;
            out_mean_r  <= (mean_r[AluBits-1:32] != '0) ? '1 : mean_r[31:0];
            out_var_r   <= (var_r[AluBits-1:56] != '0) ? '1 : var_r[55:0];
            out_sd_r    <= sd_r;
            out_empty_r <= 1'b0;
            out_drop_r  <= ovf_r;
            count_r     <= '0;
            sum_r       <= '0;
            sumsq_r     <= '0;
            min_r       <= '1;
            max_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= S_LOAD;
          end else begin
            idx_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_MED_SCAN;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // result ports
  assign out_valid        = out_valid_r;
  assign out_sample_count = out_count_r;
  assign out_min_us       = out_min_r;
  assign out_max_us       = out_max_r;
  assign out_median_us    = out_med_r;
  assign out_mean_q       = out_mean_r;
  assign out_variance_q   = out_var_r;
  assign out_stddev_q     = out_sd_r;
  assign out_empty_set    = out_empty_r;
  assign out_dropped      = out_drop_r;

  // checks
  `LSS_ASSERT_NEXT(a_one_beat, clk, rst_n, out_valid_r, !out_valid_r)
  `LSS_ASSERT_SAME(a_empty_flag, clk, rst_n, out_valid_r, out_empty_r == (out_count_r == '0))
  `LSS_ASSERT_NEXT(a_last_busy, clk, rst_n, accept && in_last, busy)
  `LSS_ASSERT_SAME(a_count_cap, clk, rst_n, 1'b1, count_r <= CountBits'(MaxSamples))
endmodule
`default_nettype wire
